/* sv/sff_pkg.sv */
// Shared types for the smoke frame filter: action codes, the input item layout,
// the result layout and the controller/datapath command and status bundles.
// No dependencies.
package sff_pkg;

  typedef enum logic [2:0] {
    ACT_WRITE  = 3'd0,
    ACT_READ   = 3'd1,
    ACT_UPDATE = 3'd2,
    ACT_SEED   = 3'd3,
    ACT_MOVE   = 3'd4
  } action_e;

  // Request payload, last field in the lowest bits
  typedef struct packed {
    logic signed [8:0] move_dy;
    logic signed [8:0] move_dx;
    logic [7:0]        seed_below;
    logic [7:0]        seed_right;
    logic [7:0]        seed_left;
    logic [7:0]        seed_center;
    logic signed [1:0] drift;
    logic [7:0]        pixel_value;
    logic [7:0]        row;
    logic [7:0]        col;
  } item_t;

  typedef struct packed {
    logic [7:0] source_row;
    logic [7:0] source_col;
    logic       hit_bottom;
    logic [7:0] read_data;
  } result_t;

  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 32;

  typedef struct packed {
    logic clear;
    logic capture;
    logic pix_wr;
    logic pix_rd;
    logic seed_c;
    logic seed_l;
    logic seed_r;
    logic move;
    logic walk;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic walk_done;
  } status_t;

endpackage

/* sv/smoke_frame_filter_top.sv */
// Top level of the smoke frame filter: stream ports, sequencer and datapath.
// Depends on sff_pkg, sff_ctrl and sff_datapath.
//
// Holds a WIDTH x HEIGHT byte frame in two banks (even and odd rows) plus a
// smoke source position. After reset the block clears the frame, one address
// per bank per cycle, before the first request is accepted. Each request
// yields one result. A row update walks the columns one per cycle, reading
// the row below and the row under that from the two banks side by side. A
// finished result waits in an output register, so the next request is taken
// while it is still unclaimed.
module smoke_frame_filter_top
  import sff_pkg::*;
#(
  parameter int unsigned WIDTH  = 256,
  parameter int unsigned HEIGHT = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // col[7:0], row[15:8], pixel_value[23:16], drift[25:24], seed_center[33:26],
  // seed_left[41:34], seed_right[49:42], seed_below[57:50], move_dx[66:58],
  // move_dy[75:67], zero[79:76]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // action[2:0]
  input  logic [2:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // read_data[7:0], hit_bottom[8], source_col[16:9], source_row[24:17], zero[31:25]
  output logic [OutDataW-1:0] m_axis_tdata
);

  cmd_t    cmd;
  status_t status;
  item_t   item;
  result_t result;

  assign item         = item_t'(s_axis_tdata[$bits(item_t)-1:0]);
  assign m_axis_tdata = OutDataW'(result);

  sff_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .action_i    (s_axis_tuser),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  sff_datapath #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .item_i   (item),
    .status_o (status),
    .result_o (result)
  );

endmodule

/* sv/sff_ctrl.sv */
// Sequencer for the smoke frame filter: clearing pass, request decode,
// per-action steps and the output handshake. Depends on sff_pkg.
module sff_ctrl
  import sff_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    [2:0] action_i,
  input  logic    out_ready_i,
  input  status_t status_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  output cmd_t    cmd_o
);

  typedef enum logic [9:0] {
    ST_CLEAR  = 10'b00_0000_0001,
    ST_IDLE   = 10'b00_0000_0010,
    ST_WRPIX  = 10'b00_0000_0100,
    ST_RDPIX  = 10'b00_0000_1000,
    ST_SEED0  = 10'b00_0001_0000,
    ST_SEED1  = 10'b00_0010_0000,
    ST_SEED2  = 10'b00_0100_0000,
    ST_MOVE   = 10'b00_1000_0000,
    ST_WALK   = 10'b01_0000_0000,
    ST_RESULT = 10'b10_0000_0000
  } state_e;

  state_e  state_q, state_d;
  logic    out_valid_q, out_valid_d;
  action_e action;

  assign action      = action_e'(action_i);
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          unique case (action)
            ACT_WRITE:  state_d = ST_WRPIX;
            ACT_READ:   state_d = ST_RDPIX;
            ACT_UPDATE: state_d = ST_WALK;
            ACT_SEED:   state_d = ST_SEED0;
            ACT_MOVE:   state_d = ST_MOVE;
            default:    state_d = ST_RESULT;
          endcase
        end
      end
      ST_WRPIX: begin
        cmd_o.pix_wr = 1'b1;
        state_d      = ST_RESULT;
      end
      ST_RDPIX: begin
        cmd_o.pix_rd = 1'b1;
        state_d      = ST_RESULT;
      end
      ST_SEED0: begin
        cmd_o.seed_c = 1'b1;
        state_d      = ST_SEED1;
      end
      ST_SEED1: begin
        cmd_o.seed_l = 1'b1;
        state_d      = ST_SEED2;
      end
      ST_SEED2: begin
        cmd_o.seed_r = 1'b1;
        state_d      = ST_RESULT;
      end
      ST_MOVE: begin
        cmd_o.move = 1'b1;
        state_d    = ST_RESULT;
      end
      ST_WALK: begin
        cmd_o.walk = 1'b1;
        if (status_i.walk_done) state_d = ST_RESULT;
      end
      ST_RESULT: begin
        // wait for the output slot to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* sv/sff_datapath.sv */
// Datapath for the smoke frame filter: two frame banks (even and odd rows),
// source position, row-update walk pipeline and result register.
// Depends on sff_pkg; driven by sff_ctrl commands.
module sff_datapath
  import sff_pkg::*;
#(
  parameter int unsigned WIDTH  = 256,
  parameter int unsigned HEIGHT = 256
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cmd_t    cmd_i,
  input  item_t   item_i,
  output status_t status_o,
  output result_t result_o
);

  localparam int unsigned XW  = $clog2(WIDTH);
  localparam int unsigned YW  = $clog2(HEIGHT);
  localparam int unsigned AW  = XW + YW - 1;            // bank address: {y[YW-1:1], x}
  localparam int unsigned KW  = XW + 2;                 // signed column index
  localparam int unsigned CW  = (XW > 8 ? XW : 8) + 1;
  localparam int unsigned RW  = (YW > 9 ? YW : 9) + 1;
  localparam int unsigned MXY = (XW > YW ? XW : YW);
  localparam int unsigned MW  = (MXY > 9 ? MXY : 9) + 2;

  localparam logic signed [KW-1:0] KWidth  = KW'(WIDTH);
  localparam logic signed [KW-1:0] KLast   = KW'(WIDTH + 1);
  localparam logic signed [MW-1:0] XMax    = MW'(WIDTH - 2);
  localparam logic signed [MW-1:0] YMax    = MW'(HEIGHT - 2);
  localparam logic signed [MW-1:0] YLow    = MW'(2);

  function automatic logic [AW-1:0] addr_of(input logic [YW-1:0] y, input logic [XW-1:0] x);
    addr_of = {y[YW-1:1], x};
  endfunction

  // ---------------------------------------------------------------- registers
  item_t                 item_q;
  logic [XW-1:0]         src_x_q, src_x_d;
  logic [YW-1:0]         src_y_q, src_y_d;
  logic                  hit_q;
  logic                  rd_val_q;
  logic                  rd_bank_q;
  logic [AW-1:0]         clr_q;
  logic signed [KW-1:0]  k_q;
  logic signed [KW-1:0]  j0_q;
  logic signed [1:0]     d_q;
  logic                  proc_q;
  logic                  rs_ok_q, rb_ok_q;
  logic [7:0]            cur_q, left_q;
  result_t               res_q;

  // ---------------------------------------------------------------- bank ports
  logic [1:0]            we, re;
  logic [1:0][AW-1:0]    wa, ra;
  logic [1:0][7:0]       wd, rdq;

  for (genvar b = 0; b < 2; b++) begin : g_bank
    logic [7:0] mem [2**AW];
    always_ff @(posedge clk_i) begin
      if (we[b]) mem[wa[b]] <= wd[b];
      if (re[b]) rdq[b] <= mem[ra[b]];
    end
  end

  // ---------------------------------------------------------------- decode
  logic                  col_ok, row_ok;
  logic [XW-1:0]         px_x;
  logic [YW-1:0]         px_y;
  logic [RW-1:0]         r_w, s_w, b_w;
  logic                  r_ok, s_ok, b_ok, sb;
  logic signed [KW-1:0]  kb, j, t, d_ext;
  logic                  k_ok, kb_ok, t_ok, issue, active;
  logic [7:0]            rs, rb, cur_dec;
  logic [9:0]            sum;
  logic signed [1:0]     d_in;
  logic signed [MW-1:0]  nx, ny;
  logic                  bottom;

  assign col_ok = CW'(item_q.col) < CW'(WIDTH);
  assign row_ok = RW'(item_q.row) < RW'(HEIGHT);
  assign px_x   = XW'(item_q.col);
  assign px_y   = YW'(item_q.row);

  assign r_w  = RW'(item_q.row);
  assign s_w  = r_w + RW'(1);
  assign b_w  = r_w + RW'(2);
  assign r_ok = r_w < RW'(HEIGHT);
  assign s_ok = s_w < RW'(HEIGHT);
  assign b_ok = b_w < RW'(HEIGHT);
  assign sb   = s_w[0];

  assign d_ext = {{(KW-2){d_q[1]}}, d_q};
  assign kb    = k_q - KW'(1);
  assign j     = k_q - KW'(2);
  assign t     = j - d_ext;
  assign k_ok  = !k_q[KW-1] && (k_q < KWidth);
  assign kb_ok = !kb[KW-1] && (kb < KWidth);
  assign t_ok  = !t[KW-1] && (t < KWidth);
  assign issue = (k_q <= KWidth);

  assign rs      = rs_ok_q ? rdq[sb] : 8'd0;
  assign rb      = rb_ok_q ? rdq[~sb] : 8'd0;
  assign active  = cmd_i.walk && proc_q && (j >= j0_q) && (cur_q != 8'd0);
  assign cur_dec = cur_q - 8'd1;
  assign sum     = {2'b00, cur_dec} + {2'b00, rs} + {2'b00, left_q} + {2'b00, rb};

  // drift pattern 2'b10 saturates to -1
  assign d_in = (item_i.drift == 2'sb10) ? 2'sb11 : item_i.drift;

  assign status_o.clear_done = &clr_q;
  assign status_o.walk_done  = (k_q == KLast);

  // ---------------------------------------------------------------- bank drive
  always_comb begin
    we = '0;
    re = '0;
    wa = '0;
    ra = '0;
    wd = '0;
    if (cmd_i.clear) begin
      we = 2'b11;
      wa[0] = clr_q;
      wa[1] = clr_q;
    end
    if (cmd_i.pix_wr && col_ok && row_ok) begin
      we[px_y[0]] = 1'b1;
      wa[px_y[0]] = addr_of(px_y, px_x);
      wd[px_y[0]] = item_q.pixel_value;
    end
    if (cmd_i.pix_rd) begin
      re[px_y[0]] = 1'b1;
      ra[px_y[0]] = addr_of(px_y, px_x);
    end
    if (cmd_i.seed_c) begin
      we[src_y_q[0]] = 1'b1;
      wa[src_y_q[0]] = addr_of(src_y_q, src_x_q);
      wd[src_y_q[0]] = item_q.seed_center;
      if ((YW + 1)'(src_y_q) + (YW + 1)'(1) < (YW + 1)'(HEIGHT)) begin
        we[~src_y_q[0]] = 1'b1;
        wa[~src_y_q[0]] = addr_of(src_y_q + YW'(1), src_x_q);
        wd[~src_y_q[0]] = item_q.seed_below;
      end
    end
    if (cmd_i.seed_l && (src_x_q != '0)) begin
      we[src_y_q[0]] = 1'b1;
      wa[src_y_q[0]] = addr_of(src_y_q, src_x_q - XW'(1));
      wd[src_y_q[0]] = item_q.seed_left;
    end
    if (cmd_i.seed_r && ((XW + 1)'(src_x_q) + (XW + 1)'(1) < (XW + 1)'(WIDTH))) begin
      we[src_y_q[0]] = 1'b1;
      wa[src_y_q[0]] = addr_of(src_y_q, src_x_q + XW'(1));
      wd[src_y_q[0]] = item_q.seed_right;
    end
    if (cmd_i.walk) begin
      // row s reads one column ahead; row s+1 reads the column behind it
      re[sb]  = issue;
      ra[sb]  = addr_of(YW'(s_w), k_q[XW-1:0]);
      re[~sb] = issue;
      ra[~sb] = addr_of(YW'(b_w), kb[XW-1:0]);
      if (active) begin
        we[sb]  = 1'b1;
        wa[sb]  = addr_of(YW'(s_w), j[XW-1:0]);
        wd[sb]  = cur_dec;
        we[~sb] = r_ok && t_ok;
        wa[~sb] = addr_of(YW'(r_w), t[XW-1:0]);
        wd[~sb] = sum[9:2];
      end
    end
  end

  // ---------------------------------------------------------------- source move
  always_comb begin
    nx      = {{(MW-XW){1'b0}}, src_x_q} + {{(MW-9){item_q.move_dx[8]}}, item_q.move_dx};
    ny      = {{(MW-YW){1'b0}}, src_y_q} + {{(MW-9){item_q.move_dy[8]}}, item_q.move_dy};
    bottom  = 1'b0;
    src_x_d = XW'(nx);
    src_y_d = YW'(ny);
    if (nx > XMax) begin
      src_x_d = XW'(XMax);
    end else if (nx[MW-1]) begin
      src_x_d = '0;
    end
    if (ny > YMax) begin
      src_y_d = YW'(YMax);
      bottom  = 1'b1;
    end else if (ny < YLow) begin
      src_y_d = '0;
    end
  end

  // ---------------------------------------------------------------- control regs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_x_q  <= XW'(WIDTH / 2);
      src_y_q  <= YW'(HEIGHT / 2);
      hit_q    <= 1'b0;
      rd_val_q <= 1'b0;
      clr_q    <= '0;
      k_q      <= '0;
      proc_q   <= 1'b0;
      rs_ok_q  <= 1'b0;
      rb_ok_q  <= 1'b0;
    end else begin
      if (cmd_i.clear) clr_q <= clr_q + AW'(1);
      if (cmd_i.capture) begin
        hit_q    <= 1'b0;
        rd_val_q <= 1'b0;
        proc_q   <= 1'b0;
        // first issued column sits one left of the first written column
        k_q      <= (d_in > 2'sd0) ? KW'(0) : {KW{1'b1}};
      end
      if (cmd_i.pix_rd) rd_val_q <= col_ok && row_ok;
      if (cmd_i.move) begin
        src_x_q <= src_x_d;
        src_y_q <= src_y_d;
        hit_q   <= bottom;
      end
      if (cmd_i.walk) begin
        k_q     <= k_q + KW'(1);
        proc_q  <= issue;
        rs_ok_q <= issue && k_ok && s_ok;
        rb_ok_q <= issue && kb_ok && b_ok;
      end
    end
  end

  // ---------------------------------------------------------------- payload regs
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= item_i;
      d_q    <= d_in;
      j0_q   <= (d_in > 2'sd0) ? KW'(1) : KW'(0);
      cur_q  <= 8'd0;
      left_q <= 8'd0;
    end
    if (cmd_i.pix_rd) rd_bank_q <= px_y[0];
    if (cmd_i.walk && proc_q) begin
      left_q <= active ? cur_dec : cur_q;
      cur_q  <= rs;
    end
    if (cmd_i.load) begin
      res_q.read_data  <= rd_val_q ? rdq[rd_bank_q] : 8'd0;
      res_q.hit_bottom <= hit_q;
      res_q.source_col <= 8'(src_x_q);
      res_q.source_row <= 8'(src_y_q);
    end
  end

  assign result_o = res_q;

endmodule

/* test/smoke_frame_filter_checker.sv */
// Checker for the smoke frame filter: watches both stream channels, keeps its
// own copy of the frame and the source position, and compares every result.
// Depends on sff_pkg.
module smoke_frame_filter_checker
  import sff_pkg::*;
#(
  parameter int unsigned WIDTH  = 256,
  parameter int unsigned HEIGHT = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [InDataW-1:0]  s_tdata_i,
  input  logic [2:0]          s_tuser_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [OutDataW-1:0] m_tdata_i,
  output int                  fail_count_o,
  output int                  outstanding_o
);

  logic [7:0] frame_mem [WIDTH*HEIGHT];
  int         src_x;
  int         src_y;
  int         fails;
  result_t    due_results_q [$];

  function automatic logic [7:0] px_at(input int x, input int y);
    if (x < 0 || y < 0 || x >= int'(WIDTH) || y >= int'(HEIGHT)) return 8'd0;
    return frame_mem[y * int'(WIDTH) + x];
  endfunction

  function automatic void px_put(input int x, input int y, input logic [7:0] v);
    if (x < 0 || y < 0 || x >= int'(WIDTH) || y >= int'(HEIGHT)) return;
    frame_mem[y * int'(WIDTH) + x] = v;
  endfunction

  // Left to right, so the left neighbour has already been cooled by one
  function automatic void burn_row(input int r, input int d);
    int         s;
    int         sum;
    logic [7:0] p;
    s = r + 1;
    for (int j = (d > 0) ? d : 0; j < int'(WIDTH); j++) begin
      p = px_at(j, s);
      if (p != 8'd0) begin
        p = p - 8'd1;
        px_put(j, s, p);
        sum = int'(p) + int'(px_at(j + 1, s)) + int'(px_at(j - 1, s)) +
              int'(px_at(j, s + 1));
        px_put(j - d, r, 8'(sum / 4));
      end
    end
  endfunction

  function automatic result_t smoke_step(input logic [2:0] act, input item_t it);
    result_t res;
    int      d;
    res = '0;
    case (act)
      ACT_WRITE: px_put(int'(it.col), int'(it.row), it.pixel_value);
      ACT_READ:  res.read_data = px_at(int'(it.col), int'(it.row));
      ACT_UPDATE: begin
        d = int'(it.drift);
        if (d < -1) d = -1;   // the unused pattern saturates
        burn_row(int'(it.row), d);
      end
      ACT_SEED: begin
        px_put(src_x, src_y, it.seed_center);
        px_put(src_x - 1, src_y, it.seed_left);
        px_put(src_x + 1, src_y, it.seed_right);
        px_put(src_x, src_y + 1, it.seed_below);
      end
      ACT_MOVE: begin
        src_x += int'(it.move_dx);
        src_y += int'(it.move_dy);
        if (src_x > int'(WIDTH) - 2) src_x = int'(WIDTH) - 2;
        if (src_x < 0) src_x = 0;
        if (src_y > int'(HEIGHT) - 2) begin
          src_y = int'(HEIGHT) - 2;
          res.hit_bottom = 1'b1;
        end else if (src_y < 2) begin
          src_y = 0;
        end
      end
      default: ;
    endcase
    res.source_col = 8'(src_x);
    res.source_row = 8'(src_y);
    return res;
  endfunction

  task automatic check_field(input string name, input int want, input logic [7:0] got);
    if (got !== 8'(want)) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t got;
    if (!rst_ni) begin
      for (int i = 0; i < int'(WIDTH * HEIGHT); i++) frame_mem[i] = 8'd0;
      src_x = int'(WIDTH) / 2;
      src_y = int'(HEIGHT) / 2;
      fails = 0;
      due_results_q.delete();
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      // results leave before the request taken at the same edge is predicted
      if (m_tvalid_i && m_tready_i) begin
        got = result_t'(m_tdata_i[$bits(result_t)-1:0]);
        if (due_results_q.size() == 0) begin
          fails++;
          $display("%0t: result with nothing expected, expected none, got %h",
                   $time, m_tdata_i);
        end else begin
          want = due_results_q.pop_front();
          check_field("read_data", int'(want.read_data), got.read_data);
          check_field("hit_bottom", int'(want.hit_bottom), 8'(got.hit_bottom));
          check_field("source_col", int'(want.source_col), got.source_col);
          check_field("source_row", int'(want.source_row), got.source_row);
          check_field("tdata padding", 0, 8'(m_tdata_i[OutDataW-1:$bits(result_t)]));
        end
      end
      if (s_tvalid_i && s_tready_i)
        due_results_q.push_back(smoke_step(s_tuser_i, item_t'(s_tdata_i[$bits(item_t)-1:0])));
      fail_count_o  <= fails;
      outstanding_o <= due_results_q.size();
    end
  end

endmodule

/* test/smoke_frame_filter_top_test.sv */
// Testbench top for the smoke frame filter: clock, reset, request stimulus,
// receiver stalls and the verdict. Depends on sff_pkg, smoke_frame_filter_top
// and smoke_frame_filter_checker.
module smoke_frame_filter_top_test
  import sff_pkg::*;
();

  localparam int unsigned WIDTH       = 256;
  localparam int unsigned HEIGHT      = 256;
  localparam int          RANDOM_REQS = 1800;
  localparam int          HOLD_CYCLES = 3000;

  // action codes the block ignores
  localparam logic [2:0] ACT_RSVD5 = 3'd5;
  localparam logic [2:0] ACT_RSVD6 = 3'd6;
  localparam logic [2:0] ACT_RSVD7 = 3'd7;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [2:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  int fail_count;
  int outstanding;
  bit hold_req;
  int burst_left;
  int n_counted;

  smoke_frame_filter_top #(
    .WIDTH (WIDTH),
    .HEIGHT(HEIGHT)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  smoke_frame_filter_checker #(
    .WIDTH (WIDTH),
    .HEIGHT(HEIGHT)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic item_t any_item();
    return item_t'({$urandom(), $urandom(), 12'($urandom())});
  endfunction

  function automatic logic [1:0] pick_drift();
    case ($urandom_range(0, 7))
      0:       return 2'b10;
      1, 2, 3: return 2'b11;
      4, 5:    return 2'b00;
      default: return 2'b01;
    endcase
  endfunction

  function automatic int hot_byte();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(128, 255);
  endfunction

  // Offer one request and wait for it to be taken; bursts end in a random gap
  task automatic send_req(input logic [2:0] act, input item_t it);
    int gap;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {{(InDataW - $bits(item_t)){1'b0}}, it};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (act <= ACT_MOVE) n_counted++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= {$urandom(), $urandom(), 16'($urandom())};
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic write_px(input int c, input int r, input int v);
    item_t it;
    it = any_item();
    it.col = 8'(c);
    it.row = 8'(r);
    it.pixel_value = 8'(v);
    send_req(ACT_WRITE, it);
  endtask

  task automatic read_px(input int c, input int r);
    item_t it;
    it = any_item();
    it.col = 8'(c);
    it.row = 8'(r);
    send_req(ACT_READ, it);
  endtask

  task automatic burn(input int r, input logic [1:0] d);
    item_t it;
    it = any_item();
    it.row = 8'(r);
    it.drift = d;
    send_req(ACT_UPDATE, it);
  endtask

  task automatic seed(input int cv, input int lv, input int rv, input int bv);
    item_t it;
    it = any_item();
    it.seed_center = 8'(cv);
    it.seed_left = 8'(lv);
    it.seed_right = 8'(rv);
    it.seed_below = 8'(bv);
    send_req(ACT_SEED, it);
  endtask

  task automatic move(input int dx, input int dy);
    item_t it;
    it = any_item();
    it.move_dx = 9'(dx);
    it.move_dy = 9'(dy);
    send_req(ACT_MOVE, it);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // Park the source at a known spot, seed it and let the flames rise a few rows
  task automatic fire_run();
    int x;
    int y;
    int n;
    x = ($urandom_range(0, 9) == 0) ? 254 * $urandom_range(0, 1) : $urandom_range(1, 253);
    y = $urandom_range(2, 254);
    move(-255, -255);
    move(x, y);
    seed(hot_byte(), hot_byte(), hot_byte(), hot_byte());
    n = $urandom_range(0, 4);
    repeat (n) write_px(x + $urandom_range(0, 6) - 3, y + $urandom_range(0, 2), hot_byte());
    n = $urandom_range(1, 4);
    for (int k = 0; k < n; k++) burn(y - k, pick_drift());
    n = $urandom_range(1, 4);
    repeat (n) read_px(x + $urandom_range(0, 4) - 2, y - $urandom_range(0, 3));
    if ($urandom_range(0, 2) == 0) move($urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4);
  endtask

  // Receiver: stall patterns that change after spans of random length
  initial begin
    int mode;
    int span;
    m_axis_tready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 300);
      for (int tick = 0; tick < span; tick++) begin
        @(posedge clk_i);
        if (hold_req) begin
          hold_req = 1'b0;
          m_axis_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk_i);
        end
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= (tick % 3 == 0);
        endcase
      end
    end
  end

  initial begin
    bit held;
    bit drained;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    rst_ni        = 1'b0;
    hold_req      = 1'b0;
    burst_left    = 1;
    n_counted     = 0;
    held          = 1'b0;
    drained       = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: corners, every action, off-frame neighbours and targets
    read_px(0, 0);
    write_px(0, 0, 255);
    write_px(255, 255, 8'hAA);
    write_px(255, 0, 1);
    read_px(0, 0);
    read_px(255, 255);
    seed(255, 8'h80, 8'h7F, 1);
    burn(127, 2'b00);
    burn(127, 2'b01);
    burn(126, 2'b11);
    burn(126, 2'b10);
    read_px(128, 127);
    burn(255, 2'b00);
    move(-255, -255);
    seed(9, 8, 7, 6);
    read_px(0, 1);
    move(255, 255);
    seed(50, 60, 70, 80);
    burn(253, 2'b11);
    burn(254, 2'b11);
    move(0, 1);
    move(-253, -253);
    move(0, 2);
    send_req(ACT_RSVD5, any_item());
    send_req(ACT_RSVD6, any_item());
    send_req(ACT_RSVD7, any_item());

    n_counted = 0;
    while (n_counted < RANDOM_REQS) begin
      if (!held && n_counted > 600) begin
        // receiver holds off while requests keep coming
        held = 1'b1;
        hold_req = 1'b1;
        burst_left = 64;
        repeat (20) write_px($urandom_range(0, 255), $urandom_range(0, 255), $urandom());
      end else if (!drained && n_counted > 1200) begin
        drained = 1'b1;
        wait_idle();
      end else if ($urandom_range(0, 3) != 0) begin
        fire_run();
      end else begin
        repeat ($urandom_range(1, 4)) send_req(3'($urandom_range(0, 7)), any_item());
      end
    end

    wait_idle();
    repeat (WIDTH + 20) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("smoke_frame_filter_top_test OK");
    end else begin
      $display("smoke_frame_filter_top_test NOT OK");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("smoke_frame_filter_top_test NOT OK");
    $finish;
  end

endmodule
